>>> rtl/frma_pkg.sv
// frame rate moving average: shared constants, widths and controller/datapath structs
// no dependencies; imported by frma_ctrl, frma_dpath and frame_rate_moving_average
`default_nettype none

package frma_pkg;

	// ring depth and timestamp width
	localparam int MAX_WINDOW = 64;
	localparam int STAMP_BITS = 32;

	// configuration field widths and reset values
	localparam int WIN_CFG_W = 7;
	localparam int TPS_W     = 32;
	localparam logic [WIN_CFG_W-1:0] WINDOW_RESET = WIN_CFG_W'(10);
	localparam logic [TPS_W-1:0]     TPS_RESET    = TPS_W'(1000);

	// register indexes on the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = CFG_IDX_W'(1);

	// derived widths
	localparam int RING_AW   = $clog2(MAX_WINDOW);
	localparam int WIN_N_W   = $clog2(MAX_WINDOW + 1);
	localparam int TOTAL_W   = STAMP_BITS + RING_AW;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W    = TPS_W + WIN_N_W;
	localparam int NUM_W     = PROD_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(NUM_W + 1);
	localparam int RATE_W    = 24;
	localparam int IVL_W     = 32;

	// controller to datapath
	typedef struct packed {
		logic capture;    // take timestamp, form interval
		logic read;       // read ring slot, form ticks * window
		logic update;     // write ring, update total, load divider
		logic div_step;   // one restoring division step
		logic load_out;   // fill output register
		logic rate_ok;    // result carries a computed rate
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic baseline_seen;
		logic interval_zero;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/frma_ctrl.sv
// frame rate moving average: sequencing state machine and output word handshake
// depends on frma_pkg
`default_nettype none

module frma_ctrl
	import frma_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rate_ok_q;
	logic             full_q;
	logic             in_fire;
	logic             out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = full_q;
	assign out_free  = !full_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_fire;
		cmd.read     = (state_q == ST_READ);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && out_free;
		cmd.rate_ok  = rate_ok_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			rate_ok_q <= 1'b0;
			full_q    <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				full_q <= 1'b1;
			end else if (out_ready) begin
				full_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						rate_ok_q <= 1'b0;
						state_q   <= status.baseline_seen ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					if (status.interval_zero) begin
						state_q <= ST_DONE;
					end else begin
						rate_ok_q <= 1'b1;
						state_q   <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					cnt_q   <= CNT_W'(NUM_W);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider never steps with an exhausted count
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("divider stepping with zero count");

	// a word is never loaded over one that is neither free nor being taken
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!full_q || out_ready))
		else $error("output register overwritten");

	// an accepted word goes to the ring read or straight to the result
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_READ || state_q == ST_DONE))
		else $error("bad state after accept");

	// a computed rate only follows a full division
	a_rate_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rate_ok_q && $past(state_q) != ST_DONE)
			|-> $past(state_q) == ST_DIV)
		else $error("rate result without division");

endmodule

`default_nettype wire

>>> rtl/frma_dpath.sv
// frame rate moving average: interval ring, running total, bit-serial divider, result register
// depends on frma_pkg; driven by frma_ctrl commands
`default_nettype none

module frma_dpath
	import frma_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	input  wire logic [STAMP_BITS-1:0] stamp,
	input  wire logic                  wr_window,
	input  wire logic                  wr_tps,
	input  wire logic [TPS_W-1:0]      cfg_value,
	output status_t                    status,
	output logic [RATE_W-1:0]          frame_rate,
	output logic [IVL_W-1:0]           interval_ticks,
	output logic                       rate_valid
);

	// configuration
	logic [WIN_CFG_W-1:0] window_q;
	logic [TPS_W-1:0]     tps_q;

	// state
	logic [STAMP_BITS-1:0] last_q;
	logic                  baseline_q;
	logic [RING_AW-1:0]    pos_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [MAX_WINDOW-1:0] valid_q;
	logic [STAMP_BITS-1:0] ring_mem [MAX_WINDOW];

	// working registers
	logic [STAMP_BITS-1:0] interval_q;
	logic [STAMP_BITS-1:0] rd_q;
	logic                  rdv_q;
	logic [PROD_W-1:0]     prod_q;
	logic [TOTAL_W-1:0]    rem_q;
	logic [NUM_W-1:0]      dvd_q;

	// result register
	logic [RATE_W-1:0] rate_out_q;
	logic [IVL_W-1:0]  ivl_out_q;
	logic              rv_out_q;

	logic [WIN_N_W-1:0]    n_eff;
	logic [RING_AW-1:0]    pos_use;
	logic                  pos_wrap;
	logic [STAMP_BITS-1:0] old_ivl;
	logic [TOTAL_W:0]      rem_sh;
	logic [TOTAL_W:0]      rem_diff;
	logic                  qbit;
	logic [RATE_W-1:0]     rate_sat;

	// window clamped to 1..MAX_WINDOW
	always_comb begin
		if (window_q == '0) begin
			n_eff = WIN_N_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			n_eff = WIN_N_W'(MAX_WINDOW);
		end else begin
			n_eff = WIN_N_W'(window_q);
		end
	end

	assign pos_use  = (WIN_N_W'(pos_q) >= n_eff) ? '0 : pos_q;
	assign pos_wrap = (WIN_N_W'(pos_use) + WIN_N_W'(1)) >= n_eff;
	assign old_ivl  = rdv_q ? rd_q : '0;

	// restoring division step, remainder stays below the divisor
	assign rem_sh   = {rem_q, dvd_q[NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, total_q};
	assign qbit     = !rem_diff[TOTAL_W];

	assign rate_sat = (|dvd_q[NUM_W-1:RATE_W]) ? {RATE_W{1'b1}} : dvd_q[RATE_W-1:0];

	assign status.baseline_seen = baseline_q;
	assign status.interval_zero = (interval_q == '0);

	assign frame_rate     = rate_out_q;
	assign interval_ticks = ivl_out_q;
	assign rate_valid     = rv_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= WINDOW_RESET;
			tps_q      <= TPS_RESET;
			last_q     <= '0;
			baseline_q <= 1'b0;
			pos_q      <= '0;
			total_q    <= '0;
			valid_q    <= '0;
		end else begin
			if (wr_tps) begin
				tps_q <= cfg_value;
			end
			if (wr_window) begin
				window_q <= cfg_value[WIN_CFG_W-1:0];
				pos_q    <= '0;
				total_q  <= '0;
				valid_q  <= '0;
			end else if (cmd.update) begin
				total_q          <= total_q - TOTAL_W'(old_ivl) + TOTAL_W'(interval_q);
				valid_q[pos_use] <= 1'b1;
				pos_q            <= pos_wrap ? '0 : RING_AW'(pos_use + RING_AW'(1));
			end
			if (cmd.capture) begin
				last_q     <= stamp;
				baseline_q <= 1'b1;
			end
		end
	end

	// ring storage, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			ring_mem[pos_use] <= interval_q;
		end
		if (cmd.read) begin
			rd_q <= ring_mem[pos_use];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			interval_q <= baseline_q ? (stamp - last_q) : '0;
		end
		if (cmd.read) begin
			rdv_q  <= valid_q[pos_use];
			prod_q <= {{WIN_N_W{1'b0}}, tps_q} * {{TPS_W{1'b0}}, n_eff};
		end
		if (cmd.update) begin
			rem_q <= '0;
			dvd_q <= {prod_q, {FRAC_BITS{1'b0}}};
		end else if (cmd.div_step) begin
			rem_q <= qbit ? rem_diff[TOTAL_W-1:0] : rem_sh[TOTAL_W-1:0];
			dvd_q <= {dvd_q[NUM_W-2:0], qbit};
		end
		if (cmd.load_out) begin
			rate_out_q <= (cmd.rate_ok && total_q != '0) ? rate_sat : '0;
			ivl_out_q  <= IVL_W'(interval_q);
			rv_out_q   <= cmd.rate_ok;
		end
	end

endmodule

`default_nettype wire

>>> rtl/frame_rate_moving_average.sv
// frame rate moving average: top level, configuration decode, controller and datapath
// depends on frma_pkg, frma_ctrl and frma_dpath
//
// Frame rate meter. Each input word is a frame mark with a free-running tick
// timestamp; each produces exactly one output word. The first mark after reset
// only sets the baseline (all result fields zero). Later marks give the wrapping
// tick interval, push it into a ring of the last window_size intervals with a
// running total, and report frames per second = ticks_per_second * window /
// total in unsigned 16.8 fixed point, truncated and saturated at 0xFFFFFF.
// A zero interval reports rate 0 with rate_valid low and leaves the window
// alone. Slots not yet filled since the window was cleared count as zero.
// Writing window_size clears the ring, position and total at once (per-slot
// valid bits, no clearing pass); ticks_per_second takes effect immediately.
// Sequence: a baseline word goes from acceptance straight to the result load,
// a zero-interval word reads the ring slot first, and a rate word reads the
// ring, updates ring and total and runs the 47 steps of the one-bit-per-cycle
// restoring divider (numerator 47 bits wide). Loads wait for a free output register;
// the input is ready the cycle after a load. One word is in flight at a time;
// the next input is accepted as soon as the result sits in the output register,
// even if the sink has not taken it yet. Configuration writes are always
// accepted and must only be issued while no word is in work.
`default_nettype none

module frame_rate_moving_average
	import frma_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// frame marks
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,   // [31:0] timestamp
	// results
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [55:0]                m_axis_tdata,   // [23:0] frame_rate, [55:24] interval_ticks
	output logic                       m_axis_tuser,   // [0] rate_valid
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [TPS_W-1:0]      cfg_data
);

	cmd_t              cmd;
	status_t           status;
	logic              cfg_fire;
	logic [RATE_W-1:0] frame_rate;
	logic [IVL_W-1:0]  interval_ticks;
	logic              rate_valid;

	// register writes are always accepted; unknown indexes are dropped
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	frma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	frma_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stamp          (s_axis_tdata[STAMP_BITS-1:0]),
		.wr_window      (cfg_fire && cfg_index == REG_WINDOW_SIZE),
		.wr_tps         (cfg_fire && cfg_index == REG_TICKS_PER_SEC),
		.cfg_value      (cfg_data),
		.status         (status),
		.frame_rate     (frame_rate),
		.interval_ticks (interval_ticks),
		.rate_valid     (rate_valid)
	);

	// output word packing, first field lowest
	assign m_axis_tdata = {interval_ticks, frame_rate};
	assign m_axis_tuser = rate_valid;

endmodule

`default_nettype wire
